[rtl/bhs_pkg.sv]
package bhs_pkg;

  localparam int SENSOR_COUNT_DEF = 6;

  localparam int ID_W       = 3;
  localparam int SYS_W      = 8;
  localparam int TEMP_W     = 16;
  localparam int DRAW_W     = 16;
  localparam int TIME_W     = 32;
  localparam int BUDGET_W   = 19;
  localparam int SUM_W      = BUDGET_W + 1;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ALU_W      = TIME_W + 2;

  // Lost sensors read one degree above the heat threshold
  localparam logic signed [TEMP_W-1:0] LOST_OFFSET = 16'sd16;

  localparam logic [SYS_W-1:0]           OWN_SYS_RST      = 8'd1;
  localparam logic signed [TEMP_W-1:0]   HEAT_ON_RST      = 16'sd0;
  localparam logic signed [TEMP_W-1:0]   THR_ABOVE_RST    = 16'sd960;
  localparam logic signed [TEMP_W-1:0]   RESTORE_BELOW_RST = 16'sd800;
  localparam logic [BUDGET_W-1:0]        BUDGET_RST       = 19'd1;
  localparam logic [TIME_W-1:0]          STALE_AFTER_RST  = 32'd10000;
  localparam logic signed [TEMP_W-1:0]   TEMP_RST         = HEAT_ON_RST + LOST_OFFSET;

  typedef enum logic [1:0] {
    CMD_REPORT  = 2'd0,
    CMD_CURRENT = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_SYS       = 3'd0,
    REG_HEAT_ON       = 3'd1,
    REG_THR_ABOVE     = 3'd2,
    REG_RESTORE_BELOW = 3'd3,
    REG_BUDGET        = 3'd4,
    REG_STALE_AFTER   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]               command;
    logic [SYS_W-1:0]         source_system;
    logic [ID_W-1:0]          sensor_id;
    logic signed [TEMP_W-1:0] reading;
    logic                     reading_valid;
    logic [DRAW_W-1:0]        heater_current_ma;
    logic [TIME_W-1:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0]   heater_on_mask;
    logic                radio_throttled;
    logic [BUDGET_W-1:0] total_current_ma;
    logic [MASK_W-1:0]   stale_mask;
  } out_item_t;

endpackage

[rtl/bhs_if.sv]
interface bhs_in_if import bhs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bhs_out_if import bhs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bhs_cfg_if import bhs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/budgeted_heater_scheduler.sv]
// Budgeted heater scheduler. Temperature reports and heater-current writes
// finish in the cycle they are accepted and give no result. A control tick
// gives one result transaction and keeps the input side not ready while it
// runs; its final step waits while an earlier result has not been taken.
// One shared 34-bit add/subtract unit first checks each sensor's age (two
// steps per sensor), then picks the coldest remaining sensor by a linear
// scan (N steps for N = SENSOR_COUNT sensors) followed by a threshold
// check, a current sum and a budget check for that sensor.
// Equal temperatures keep index order.
// A finished result sits in an output register, so new transactions are
// accepted while it waits to be taken. The configuration port is always ready.
module budgeted_heater_scheduler import bhs_pkg::*; #(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bhs_in_if.sink    in_if,
  bhs_out_if.source out_if,
  bhs_cfg_if.sink   cfg_if
);

  localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int IDW1  = ID_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_AGE   = 8'b0000_0010,
    ST_STALE = 8'b0000_0100,
    ST_SCAN  = 8'b0000_1000,
    ST_COLD  = 8'b0001_0000,
    ST_SUM   = 8'b0010_0000,
    ST_FIT   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [SYS_W-1:0]         own_sys_q;
  logic signed [TEMP_W-1:0] heat_on_q;
  logic signed [TEMP_W-1:0] thr_above_q;
  logic signed [TEMP_W-1:0] restore_below_q;
  logic [BUDGET_W-1:0]      budget_q;
  logic [TIME_W-1:0]        stale_after_q;

  // Per-sensor state
  logic signed [TEMP_W-1:0] temp_q [SENSOR_COUNT];
  logic [TIME_W-1:0]        last_q [SENSOR_COUNT];
  logic [DRAW_W-1:0]        draw_q [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0]  en_q;
  logic                     throttle_q;

  // Tick working registers
  logic [TIME_W-1:0]        now_q;
  logic [TIME_W-1:0]        age_q;
  logic [IDX_W-1:0]         j_q;
  logic [IDX_W-1:0]         pick_q;
  logic [SENSOR_COUNT-1:0]  picked_q;
  logic [SENSOR_COUNT-1:0]  stale_q;
  logic [IDX_W-1:0]         best_q;
  logic signed [TEMP_W-1:0] best_temp_q;
  logic                     best_vld_q;
  logic                     cold_q;
  logic [BUDGET_W-1:0]      total_q;
  logic [SUM_W-1:0]         sum_q;

  logic      out_vld_q;
  out_item_t out_q;

  // Shared add/subtract unit
  logic             alu_sub;
  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_neg;

  logic                     in_fire, cfg_fire;
  logic                     id_ok, j_last, take_best;
  logic [IDX_W-1:0]         in_idx;
  logic [TEMP_W:0]          lost_sum;
  logic signed [TEMP_W-1:0] lost_temp;

  assign in_if.ready  = (state_q == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

  assign in_fire  = in_if.valid && in_if.ready;
  assign cfg_fire = cfg_if.valid && cfg_if.ready;
  assign id_ok    = IDW1'(in_if.data.sensor_id) < IDW1'(SENSOR_COUNT);
  assign in_idx   = in_if.data.sensor_id[IDX_W-1:0];
  assign j_last   = (j_q == LAST_IDX);

  // Saturate threshold plus one degree at the top of the signed range
  assign lost_sum  = {heat_on_q[TEMP_W-1], heat_on_q} + {{1{LOST_OFFSET[TEMP_W-1]}}, LOST_OFFSET};
  assign lost_temp = (!lost_sum[TEMP_W] && lost_sum[TEMP_W-1]) ?
                     {1'b0, {(TEMP_W-1){1'b1}}} : lost_sum[TEMP_W-1:0];

  // Operand select for the shared unit
  always_comb begin
    alu_sub = 1'b1;
    alu_a   = '0;
    alu_b   = '0;
    case (state_q)
      ST_AGE: begin
        alu_a = ALU_W'(now_q);
        alu_b = ALU_W'(last_q[j_q]);
      end
      ST_STALE: begin
        // Negative means age exceeds the limit
        alu_a = ALU_W'(stale_after_q);
        alu_b = ALU_W'(age_q);
      end
      ST_SCAN: begin
        alu_a = ALU_W'(signed'(temp_q[j_q]));
        alu_b = ALU_W'(signed'(best_temp_q));
      end
      ST_COLD: begin
        alu_a = ALU_W'(signed'(best_temp_q));
        alu_b = ALU_W'(signed'(heat_on_q));
      end
      ST_SUM: begin
        alu_sub = 1'b0;
        alu_a   = ALU_W'(total_q);
        alu_b   = ALU_W'(draw_q[best_q]);
      end
      ST_FIT: begin
        alu_a = ALU_W'(sum_q);
        alu_b = ALU_W'(budget_q);
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
  end

  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  assign alu_neg = alu_res[ALU_W-1];

  // First unpicked sensor, or a strictly colder one, becomes the candidate
  assign take_best = !picked_q[j_q] && (!best_vld_q || alu_neg);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_if.data.command == CMD_TICK)) begin
          state_d = ST_AGE;
        end
      end
      ST_AGE:   state_d = ST_STALE;
      ST_STALE: state_d = j_last ? ST_SCAN : ST_AGE;
      ST_SCAN:  state_d = j_last ? ST_COLD : ST_SCAN;
      ST_COLD:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_FIT;
      ST_FIT:   state_d = (pick_q == LAST_IDX) ? ST_OUT : ST_SCAN;
      ST_OUT: begin
        if (!out_vld_q || out_if.ready) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_sys_q       <= OWN_SYS_RST;
      heat_on_q       <= HEAT_ON_RST;
      thr_above_q     <= THR_ABOVE_RST;
      restore_below_q <= RESTORE_BELOW_RST;
      budget_q        <= BUDGET_RST;
      stale_after_q   <= STALE_AFTER_RST;
    end else if (cfg_fire) begin
      case (reg_idx_e'(cfg_if.index))
        REG_OWN_SYS:       own_sys_q       <= cfg_if.data[SYS_W-1:0];
        REG_HEAT_ON:       heat_on_q       <= cfg_if.data[TEMP_W-1:0];
        REG_THR_ABOVE:     thr_above_q     <= cfg_if.data[TEMP_W-1:0];
        REG_RESTORE_BELOW: restore_below_q <= cfg_if.data[TEMP_W-1:0];
        REG_BUDGET:        budget_q        <= cfg_if.data[BUDGET_W-1:0];
        REG_STALE_AFTER:   stale_after_q   <= cfg_if.data[TIME_W-1:0];
        default: begin
          // Drop writes to unknown registers
        end
      endcase
    end
  end

  // Sensor state, tick sequencing and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        temp_q[i] <= TEMP_RST;
        last_q[i] <= '0;
        draw_q[i] <= '0;
      end
      en_q        <= '0;
      throttle_q  <= 1'b0;
      j_q         <= '0;
      pick_q      <= '0;
      picked_q    <= '0;
      stale_q     <= '0;
      best_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      now_q       <= '0;
      age_q       <= '0;
      best_q      <= '0;
      best_temp_q <= '0;
      cold_q      <= 1'b0;
      total_q     <= '0;
      sum_q       <= '0;
      out_q       <= '0;
    end else begin
      // The final step reloads the output register itself
      if (out_vld_q && out_if.ready && (state_q != ST_OUT)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (cmd_e'(in_if.data.command))
              CMD_REPORT: begin
                if (id_ok && (in_if.data.source_system == own_sys_q) &&
                    in_if.data.reading_valid) begin
                  temp_q[in_idx] <= in_if.data.reading;
                  last_q[in_idx] <= in_if.data.time_ms;
                end
              end
              CMD_CURRENT: begin
                if (id_ok) begin
                  draw_q[in_idx] <= in_if.data.heater_current_ma;
                end
              end
              CMD_TICK: begin
                // Restore test wins when both thresholds hold
                if (temp_q[0] < restore_below_q) begin
                  throttle_q <= 1'b0;
                end else if (temp_q[0] > thr_above_q) begin
                  throttle_q <= 1'b1;
                end
                now_q      <= in_if.data.time_ms;
                j_q        <= '0;
                pick_q     <= '0;
                picked_q   <= '0;
                stale_q    <= '0;
                best_vld_q <= 1'b0;
                total_q    <= '0;
              end
              default: begin
                // Ignore unknown commands
              end
            endcase
          end
        end
        ST_AGE: begin
          age_q <= alu_res[TIME_W-1:0];
        end
        ST_STALE: begin
          if (alu_neg) begin
            temp_q[j_q]  <= lost_temp;
            stale_q[j_q] <= 1'b1;
          end
          j_q <= j_last ? '0 : j_q + 1'b1;
        end
        ST_SCAN: begin
          if (take_best) begin
            best_q      <= j_q;
            best_temp_q <= temp_q[j_q];
            best_vld_q  <= 1'b1;
          end
          j_q <= j_last ? '0 : j_q + 1'b1;
        end
        ST_COLD: begin
          cold_q <= alu_neg;
        end
        ST_SUM: begin
          sum_q <= alu_res[SUM_W-1:0];
        end
        ST_FIT: begin
          // Enable only a cold heater whose draw keeps the sum under budget
          if (cold_q && alu_neg) begin
            en_q[best_q] <= 1'b1;
            total_q      <= sum_q[BUDGET_W-1:0];
          end else begin
            en_q[best_q] <= 1'b0;
          end
          picked_q[best_q] <= 1'b1;
          best_vld_q       <= 1'b0;
          pick_q           <= pick_q + 1'b1;
        end
        ST_OUT: begin
          if (!out_vld_q || out_if.ready) begin
            out_vld_q              <= 1'b1;
            out_q.heater_on_mask   <= MASK_W'(en_q);
            out_q.radio_throttled  <= throttle_q;
            out_q.total_current_ma <= total_q;
            out_q.stale_mask       <= MASK_W'(stale_q);
          end
        end
        default: begin
          j_q <= '0;
        end
      endcase
    end
  end

endmodule

[rtl/bhs_checker.sv]
module bhs_checker import bhs_pkg::*; #(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input in_item_t  in_data_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  localparam logic [MASK_W-1:0] USED_MASK = MASK_W'((2 ** SENSOR_COUNT) - 1);

  // A pending result holds until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed or dropped while stalled");

  // A tick stalls the input side while it is evaluated
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_data_i.command == CMD_TICK) |=> !in_ready_i)
    else $error("input ready right after a tick");

  // A new result only appears at the end of a tick evaluation
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without a tick in progress");

  // No heater on means no current drawn
  a_zero_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.heater_on_mask == '0) |-> (out_data_i.total_current_ma == '0))
    else $error("current reported with all heaters off");

  // Masks never flag sensors that do not exist
  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_data_i.heater_on_mask & ~USED_MASK) == '0) &&
                    ((out_data_i.stale_mask & ~USED_MASK) == '0))
    else $error("mask bit set beyond the sensor count");

endmodule

bind budgeted_heater_scheduler bhs_checker #(
  .SENSOR_COUNT (SENSOR_COUNT)
) u_bhs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_data_i   (in_if.data),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);

[tb/budgeted_heater_scheduler_tb.sv]
module budgeted_heater_scheduler_tb;
  import bhs_pkg::*;

  localparam int SENSORS = SENSOR_COUNT_DEF;
  // Extra wait at the end of the run, longer than a tick keeps the block busy.
  localparam int TICK_LATENCY = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES = 1_000_000;
  // The command field has one spare code that the block must ignore.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic clk_i;
  logic rst_ni;

  bhs_in_if  in_if ();
  bhs_out_if out_if ();
  bhs_cfg_if cfg_if ();

  budgeted_heater_scheduler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Mirror of the configuration registers.
  logic [SYS_W-1:0]         cfg_own;
  logic signed [TEMP_W-1:0] cfg_heat;
  logic signed [TEMP_W-1:0] cfg_thr_above;
  logic signed [TEMP_W-1:0] cfg_restore;
  logic [BUDGET_W-1:0]      cfg_budget;
  logic [TIME_W-1:0]        cfg_stale;

  // Mirror of the per-sensor state and the radio flag.
  logic signed [TEMP_W-1:0] temp_mirror [SENSORS];
  logic [TIME_W-1:0]        seen_ms [SENSORS];
  logic [DRAW_W-1:0]        draw_mirror [SENSORS];
  logic                     throttle_mirror;

  // Heater plans predicted for accepted ticks, oldest first.
  out_item_t expected_plans [$];

  int mismatch_total;
  int src_idle_pct;
  int sink_idle_pct;
  int cfg_round;
  int cycles;
  int result_count;
  logic [TIME_W-1:0] now_ms;

  always #5 clk_i = ~clk_i;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %0h expected %0h",
             result_count, what, got, want);
    mismatch_total++;
  endtask

  // Temperature a lost sensor falls back to: one degree above the
  // threshold, held at the top of the signed range.
  function automatic logic signed [TEMP_W-1:0] lost_reading();
    int t;
    t = int'(cfg_heat) + 16;
    if (t > 32767) t = 32767;
    return TEMP_W'(t);
  endfunction

  // Advance the mirror by one accepted input transaction; a tick pushes
  // the heater plan it must produce.
  task automatic track_item(input in_item_t it);
    out_item_t plan;
    int order [SENSORS];
    int j;
    int s;
    logic [TIME_W-1:0] age;
    logic [31:0] total;
    plan = '0;
    total = '0;
    case (it.command)
      CMD_REPORT: begin
        if (it.sensor_id < SENSORS && it.source_system == cfg_own && it.reading_valid) begin
          temp_mirror[it.sensor_id] = it.reading;
          seen_ms[it.sensor_id] = it.time_ms;
        end
      end
      CMD_CURRENT: begin
        if (it.sensor_id < SENSORS) draw_mirror[it.sensor_id] = it.heater_current_ma;
      end
      CMD_TICK: begin
        // Radio hysteresis looks at sensor 0 before the stale pass; the
        // restore test comes second and wins on conflicting thresholds.
        if (temp_mirror[0] > cfg_thr_above) throttle_mirror = 1'b1;
        if (temp_mirror[0] < cfg_restore) throttle_mirror = 1'b0;
        for (int i = 0; i < SENSORS; i++) begin
          age = it.time_ms - seen_ms[i];
          if (age > cfg_stale) begin
            temp_mirror[i] = lost_reading();
            plan.stale_mask[i] = 1'b1;
          end
        end
        // Stable insertion sort, coldest first.
        for (int i = 0; i < SENSORS; i++) begin
          j = i;
          while (j > 0 && temp_mirror[order[j-1]] > temp_mirror[i]) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = i;
        end
        // Greedy walk: enable each cold heater whose draw keeps the sum strictly under budget.
        for (int i = 0; i < SENSORS; i++) begin
          s = order[i];
          if (temp_mirror[s] < cfg_heat &&
              total + 32'(draw_mirror[s]) < 32'(cfg_budget)) begin
            total = total + 32'(draw_mirror[s]);
            plan.heater_on_mask[s] = 1'b1;
          end
        end
        plan.radio_throttled = throttle_mirror;
        plan.total_current_ma = total[BUDGET_W-1:0];
        expected_plans.push_back(plan);
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t make_item(input logic [1:0] cmd, input logic [SYS_W-1:0] src,
                                         input logic [ID_W-1:0] id,
                                         input logic signed [TEMP_W-1:0] rd,
                                         input logic ok, input logic [DRAW_W-1:0] cur,
                                         input logic [TIME_W-1:0] t);
    in_item_t it;
    it.command = cmd;
    it.source_system = src;
    it.sensor_id = id;
    it.reading = rd;
    it.reading_valid = ok;
    it.heater_current_ma = cur;
    it.time_ms = t;
    return it;
  endfunction

  // Send one input transaction. Idle gaps come before valid is raised, so a
  // back-to-back transaction keeps valid high without a drop in between.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    track_item(it);
  endtask

  // Hold the input side until every predicted plan has arrived, then let
  // the block settle before anything else is touched.
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (expected_plans.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_OWN_SYS:       cfg_own = value[SYS_W-1:0];
      REG_HEAT_ON:       cfg_heat = value[TEMP_W-1:0];
      REG_THR_ABOVE:     cfg_thr_above = value[TEMP_W-1:0];
      REG_RESTORE_BELOW: cfg_restore = value[TEMP_W-1:0];
      REG_BUDGET:        cfg_budget = value[BUDGET_W-1:0];
      REG_STALE_AFTER:   cfg_stale = value;
      default: ;
    endcase
  endtask

  // Keep the low w bits of a register value, fill the unused bits randomly.
  function automatic logic [31:0] keep_field(input logic [31:0] v, input int w);
    logic [31:0] mask;
    mask = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
    return ($urandom() & ~mask) | (v & mask);
  endfunction

  // Rotate which registers sit at their low or high extreme per round.
  function automatic int extreme_pick(input int reg_no);
    return (cfg_round + reg_no) % 5;
  endfunction

  task automatic randomize_config();
    int heat;
    int v;
    heat = $urandom_range(0, 600);
    heat = heat - 300;
    case (extreme_pick(0))
      0: v = 0;
      1: v = 255;
      default: v = $urandom_range(0, 255);
    endcase
    cfg_write(REG_OWN_SYS, keep_field(v, SYS_W));
    case (extreme_pick(1))
      0: heat = -32768;
      1: heat = 32767;
      default: ;
    endcase
    cfg_write(REG_HEAT_ON, keep_field(heat, TEMP_W));
    case (extreme_pick(2))
      0: v = -32768;
      1: v = 32767;
      default: v = heat + $urandom_range(0, 250);
    endcase
    cfg_write(REG_THR_ABOVE, keep_field(v, TEMP_W));
    case (extreme_pick(3))
      0: v = -32768;
      1: v = 32767;
      default: v = heat + $urandom_range(0, 350) - 250;
    endcase
    cfg_write(REG_RESTORE_BELOW, keep_field(v, TEMP_W));
    case (extreme_pick(4))
      0: v = 0;
      1: v = 524287;
      default: v = $urandom_range(0, 1200);
    endcase
    cfg_write(REG_BUDGET, keep_field(v, BUDGET_W));
    case (extreme_pick(5))
      0: cfg_write(REG_STALE_AFTER, 32'd0);
      1: cfg_write(REG_STALE_AFTER, 32'hFFFF_FFFF);
      default: cfg_write(REG_STALE_AFTER, 32'($urandom_range(30, 1500)));
    endcase
    cfg_round++;
  endtask

  // Mostly well-formed traffic on an advancing clock: own-system reports
  // near the threshold, modest currents, ticks. The rest is raw noise.
  function automatic in_item_t gen_item();
    in_item_t it;
    logic [95:0] raw;
    int offs;
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) now_ms = $urandom();
    else now_ms = now_ms + $urandom_range(0, 40);
    offs = $urandom_range(0, 400);
    offs = offs - 200;
    it = make_item(CMD_REPORT, cfg_own, ID_W'($urandom_range(0, SENSORS - 1)),
                   TEMP_W'(int'(cfg_heat) + offs), 1'b1,
                   DRAW_W'($urandom_range(0, 400)), now_ms);
    if ($urandom_range(0, 9) == 0) it.reading = TEMP_W'($urandom());
    if ($urandom_range(0, 9) == 0) it.heater_current_ma = DRAW_W'($urandom());
    if (pick >= 90) begin
      raw = {$urandom(), $urandom(), $urandom()};
      it = raw[$bits(in_item_t)-1:0];
    end else if (pick >= 65) begin
      it.command = CMD_TICK;
    end else if (pick >= 45) begin
      it.command = CMD_CURRENT;
    end
    return it;
  endfunction

  // After reset: a tick at time zero sees fresh sensors, one past the
  // default timeout sees all of them lost.
  task automatic test_reset_state();
    send_item(make_item(CMD_TICK, 8'd0, 3'd0, 16'sd0, 1'b0, 16'd0, 32'd0));
    send_item(make_item(CMD_TICK, 8'd0, 3'd0, 16'sd0, 1'b0, 16'd0, 32'd10001));
  endtask

  // Report filtering: foreign sender, invalid reading, ids past the sensor
  // count, the spare command code; then a tick that throttles the radio.
  task automatic test_report_filter();
    wait_results_drained();
    cfg_write(REG_OWN_SYS, 32'hFFFF_FFFF);
    send_item(make_item(CMD_REPORT, 8'hFF, 3'd0, 16'sd1000, 1'b1, 16'd0, 32'd10100));
    send_item(make_item(CMD_REPORT, 8'h00, 3'd1, -16'sd32768, 1'b1, 16'd0, 32'd10110));
    send_item(make_item(CMD_REPORT, 8'hFF, 3'd2, 16'sd32767, 1'b0, 16'd0, 32'd10120));
    send_item(make_item(CMD_REPORT, 8'hFF, 3'd7, 16'sd500, 1'b1, 16'd0, 32'd10130));
    send_item(make_item(CMD_REPORT, 8'hFF, 3'd6, 16'sd500, 1'b1, 16'd0, 32'd10140));
    send_item(make_item(CMD_CURRENT, 8'h00, 3'd7, 16'sd0, 1'b0, 16'hFFFF, 32'd10150));
    send_item(make_item(CMD_CURRENT, 8'h00, 3'd0, 16'sd0, 1'b0, 16'hFFFF, 32'd10160));
    send_item(make_item(CMD_UNKNOWN, 8'hFF, 3'd5, -16'sd1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(make_item(CMD_TICK, 8'h00, 3'd0, 16'sd0, 1'b0, 16'd0, 32'd10200));
  endtask

  // Conflicting radio thresholds, zero and full budget, and equal
  // temperatures that must keep index order in the greedy walk.
  task automatic test_radio_and_budget();
    wait_results_drained();
    cfg_write(REG_HEAT_ON, 32'hA5A5_0064);
    cfg_write(REG_THR_ABOVE, 32'd0);
    cfg_write(REG_RESTORE_BELOW, 32'd100);
    cfg_write(REG_BUDGET, 32'hFFF8_0000);
    send_item(make_item(CMD_REPORT, 8'hFF, 3'd0, 16'sd50, 1'b1, 16'd0, 32'd20000));
    send_item(make_item(CMD_REPORT, 8'hFF, 3'd1, -16'sd10, 1'b1, 16'd0, 32'd20000));
    send_item(make_item(CMD_REPORT, 8'hFF, 3'd2, -16'sd10, 1'b1, 16'd0, 32'd20001));
    send_item(make_item(CMD_REPORT, 8'hFF, 3'd3, -16'sd20, 1'b1, 16'd0, 32'd20002));
    send_item(make_item(CMD_REPORT, 8'hFF, 3'd4, 16'sd99, 1'b1, 16'd0, 32'd20003));
    send_item(make_item(CMD_REPORT, 8'hFF, 3'd5, 16'sd100, 1'b1, 16'd0, 32'd20004));
    send_item(make_item(CMD_CURRENT, 8'h00, 3'd1, 16'sd0, 1'b0, 16'd100, 32'd20005));
    send_item(make_item(CMD_CURRENT, 8'h00, 3'd2, 16'sd0, 1'b0, 16'd100, 32'd20006));
    send_item(make_item(CMD_CURRENT, 8'h00, 3'd3, 16'sd0, 1'b0, 16'd100, 32'd20007));
    send_item(make_item(CMD_TICK, 8'h00, 3'd0, 16'sd0, 1'b0, 16'd0, 32'd20010));
    wait_results_drained();
    cfg_write(REG_BUDGET, 32'h0007_FFFF);
    send_item(make_item(CMD_TICK, 8'h00, 3'd0, 16'sd0, 1'b0, 16'd0, 32'd20020));
    wait_results_drained();
    cfg_write(REG_BUDGET, 32'd250);
    send_item(make_item(CMD_TICK, 8'h00, 3'd0, 16'sd0, 1'b0, 16'd0, 32'd20030));
  endtask

  // Threshold at the top of the range saturates the lost temperature; a
  // report just before the time counter wraps stays fresh after it.
  task automatic test_stale_and_wrap();
    wait_results_drained();
    cfg_write(REG_HEAT_ON, 32'h1234_7FFF);
    cfg_write(REG_STALE_AFTER, 32'd100);
    send_item(make_item(CMD_REPORT, 8'hFF, 3'd1, 16'sd200, 1'b1, 16'd0, 32'hFFFF_FFF0));
    send_item(make_item(CMD_TICK, 8'h00, 3'd0, 16'sd0, 1'b0, 16'd0, 32'h0000_0005));
    wait_results_drained();
    cfg_write(REG_STALE_AFTER, 32'd0);
    send_item(make_item(CMD_TICK, 8'h00, 3'd0, 16'sd0, 1'b0, 16'd0, 32'h0000_0005));
    wait_results_drained();
    cfg_write(REG_STALE_AFTER, 32'hFFFF_FFFF);
    cfg_write(REG_HEAT_ON, 32'h0000_8000);
    send_item(make_item(CMD_TICK, 8'h00, 3'd0, 16'sd0, 1'b0, 16'd0, 32'h0000_0006));
  endtask

  // Random traffic; every 90 transactions drain the results and move to a
  // new register setting.
  task automatic test_random_traffic(input int items, input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    sink_idle_pct = snk_pct;
    for (int k = 0; k < items; k++) begin
      if (k % 90 == 0) begin
        wait_results_drained();
        randomize_config();
      end
      send_item(gen_item());
    end
  endtask

  // Result side: compare each accepted result with the oldest plan, then
  // pick the ready level for the next cycle.
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_plans.size() == 0) begin
        report_mismatch("result with none expected, mask", 32'(out_if.data.heater_on_mask), 0);
      end else begin
        want = expected_plans.pop_front();
        if (out_if.data.heater_on_mask !== want.heater_on_mask)
          report_mismatch("heater_on_mask", 32'(out_if.data.heater_on_mask),
                          32'(want.heater_on_mask));
        if (out_if.data.radio_throttled !== want.radio_throttled)
          report_mismatch("radio_throttled", 32'(out_if.data.radio_throttled),
                          32'(want.radio_throttled));
        if (out_if.data.total_current_ma !== want.total_current_ma)
          report_mismatch("total_current_ma", 32'(out_if.data.total_current_ma),
                          32'(want.total_current_ma));
        if (out_if.data.stale_mask !== want.stale_mask)
          report_mismatch("stale_mask", 32'(out_if.data.stale_mask), 32'(want.stale_mask));
      end
      result_count++;
    end
    out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Watchdog: end the run if the traffic never drains.
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_OWN_SYS;
    cfg_if.data = '0;
    mismatch_total = 0;
    result_count = 0;
    cfg_round = 0;
    now_ms = '0;
    src_idle_pct = 0;
    sink_idle_pct = 50;
    cfg_own = OWN_SYS_RST;
    cfg_heat = HEAT_ON_RST;
    cfg_thr_above = THR_ABOVE_RST;
    cfg_restore = RESTORE_BELOW_RST;
    cfg_budget = BUDGET_RST;
    cfg_stale = STALE_AFTER_RST;
    throttle_mirror = 1'b0;
    for (int i = 0; i < SENSORS; i++) begin
      temp_mirror[i] = TEMP_RST;
      seen_ms[i] = '0;
      draw_mirror[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_report_filter();
    test_radio_and_budget();
    test_stale_and_wrap();
    test_random_traffic(270, 15, 86);
    test_random_traffic(270, 86, 15);
    test_random_traffic(270, 0, 0);

    wait_results_drained();
    repeat (TICK_LATENCY) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
